FILE: hw/rtl/cfst_pkg.sv
package cfst_pkg;

	// Token kinds. The parser section that is reading a field carries the
	// same code as the token that the field produces.
	typedef logic [4:0] kind_t;

	localparam kind_t KIND_MAGIC        = 5'd0;
	localparam kind_t KIND_MINOR        = 5'd1;
	localparam kind_t KIND_MAJOR        = 5'd2;
	localparam kind_t KIND_POOL_COUNT   = 5'd3;
	localparam kind_t KIND_TAG          = 5'd4;
	localparam kind_t KIND_UTF8_LEN     = 5'd5;
	localparam kind_t KIND_UTF8_BYTE    = 5'd6;
	localparam kind_t KIND_INTEGER      = 5'd7;
	localparam kind_t KIND_FLOAT        = 5'd8;
	localparam kind_t KIND_LONG         = 5'd9;
	localparam kind_t KIND_DOUBLE       = 5'd10;
	localparam kind_t KIND_CLASS_NAME   = 5'd11;
	localparam kind_t KIND_STRING_IDX   = 5'd12;
	localparam kind_t KIND_REF_CLASS    = 5'd13;
	localparam kind_t KIND_REF_NAT      = 5'd14;
	localparam kind_t KIND_NAT_NAME     = 5'd15;
	localparam kind_t KIND_NAT_DESC     = 5'd16;
	localparam kind_t KIND_ACCESS       = 5'd17;
	localparam kind_t KIND_THIS         = 5'd18;
	localparam kind_t KIND_SUPER        = 5'd19;
	localparam kind_t KIND_IFACE_COUNT  = 5'd20;
	localparam kind_t KIND_IFACE        = 5'd21;
	localparam kind_t KIND_FIELD_COUNT  = 5'd22;
	localparam kind_t KIND_METHOD_COUNT = 5'd23;
	localparam kind_t KIND_MEM_ACCESS   = 5'd24;
	localparam kind_t KIND_MEM_NAME     = 5'd25;
	localparam kind_t KIND_MEM_DESC     = 5'd26;
	localparam kind_t KIND_ATTR_COUNT   = 5'd27;
	localparam kind_t KIND_ATTR_NAME    = 5'd28;
	localparam kind_t KIND_ATTR_LEN     = 5'd29;
	localparam kind_t KIND_ATTR_BYTE    = 5'd30;
	localparam kind_t KIND_ERROR        = 5'd31;

	// Owner of member and attribute tokens.
	typedef logic [1:0] owner_t;

	localparam owner_t OWNER_CLASS  = 2'd0;
	localparam owner_t OWNER_FIELD  = 2'd1;
	localparam owner_t OWNER_METHOD = 2'd2;

	// Status codes.
	typedef logic [1:0] status_t;

	localparam status_t STATUS_OK        = 2'd0;
	localparam status_t STATUS_BAD_MAGIC = 2'd1;
	localparam status_t STATUS_BAD_TAG   = 2'd2;

	// Constant pool tags.
	localparam logic [7:0] TAG_UTF8      = 8'd1;
	localparam logic [7:0] TAG_INTEGER   = 8'd3;
	localparam logic [7:0] TAG_FLOAT     = 8'd4;
	localparam logic [7:0] TAG_LONG      = 8'd5;
	localparam logic [7:0] TAG_DOUBLE    = 8'd6;
	localparam logic [7:0] TAG_CLASS     = 8'd7;
	localparam logic [7:0] TAG_STRING    = 8'd8;
	localparam logic [7:0] TAG_FIELDREF  = 8'd9;
	localparam logic [7:0] TAG_METHREF   = 8'd10;
	localparam logic [7:0] TAG_IMETHREF  = 8'd11;
	localparam logic [7:0] TAG_NAT       = 8'd12;

	localparam logic [31:0] MAGIC_WORD = 32'hCAFE_BABE;

	// One result word.
	typedef struct packed {
		kind_t       token_kind;
		logic [63:0] token_value;
		logic [15:0] entry_index;
		owner_t      owner;
		status_t     status;
		logic        class_done;
	} token_t;

endpackage

FILE: hw/rtl/cfst_if.sv
// Byte stream channel: one class-file byte per word.
interface cfst_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

// Token channel: one parsed field or payload byte per word.
interface cfst_token_if;
	logic                 valid;
	logic                 ready;
	cfst_pkg::kind_t      token_kind;
	logic [63:0]          token_value;
	logic [15:0]          entry_index;
	cfst_pkg::owner_t     owner;
	cfst_pkg::status_t    status;
	logic                 class_done;

	modport source (output valid, output token_kind, output token_value,
		output entry_index, output owner, output status, output class_done,
		input ready);
	modport sink   (input valid, input token_kind, input token_value,
		input entry_index, input owner, input status, input class_done,
		output ready);
endinterface

FILE: hw/rtl/class_file_stream_tokenizer.sv
// Class file stream tokenizer.
// A byte in the input register that finishes a field has its token loaded
// into the result register, as the parser state advances, once that register is free.
// Throughput: one byte per cycle while the sink takes tokens; the result register
// and the input register each take a new word in the cycle their old one moves on.
// Reset (arst_n low, asynchronous) returns the parser to waiting for a magic.
module class_file_stream_tokenizer (
	input logic             clk,
	input logic             arst_n,
	cfst_byte_if.sink       bytes,
	cfst_token_if.source    tokens
);
	import cfst_pkg::*;

	// Number of bytes in the field read by a section.
	function automatic logic [3:0] field_bytes(input kind_t s);
		logic [3:0] n;
		n = 4'd2;
		case (s)
			KIND_MAGIC, KIND_INTEGER, KIND_FLOAT, KIND_ATTR_LEN: n = 4'd4;
			KIND_LONG, KIND_DOUBLE:                                n = 4'd8;
			KIND_TAG, KIND_UTF8_BYTE, KIND_ATTR_BYTE:              n = 4'd1;
			default:                                               n = 4'd2;
		endcase
		return n;
	endfunction

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Result register.
	logic   valid_s2;
	token_t token_s2;

	// Parser state.
	kind_t       section_q;
	logic [2:0]  byte_pos_q;
	logic [63:0] acc_q;
	logic [15:0] pool_slot_q;
	logic [15:0] pool_total_q;
	logic [15:0] items_left_q;
	logic [15:0] item_number_q;
	logic [15:0] attrs_left_q;
	logic [15:0] attr_number_q;
	logic [31:0] payload_left_q;
	logic [7:0]  tag_q;
	owner_t      context_q;
	logic        failed_q;

	// Next-state values.
	kind_t       section_d;
	logic [2:0]  byte_pos_d;
	logic [63:0] acc_d;
	logic [15:0] pool_slot_d;
	logic [15:0] pool_total_d;
	logic [15:0] items_left_d;
	logic [15:0] item_number_d;
	logic [15:0] attrs_left_d;
	logic [15:0] attr_number_d;
	logic [31:0] payload_left_d;
	logic [7:0]  tag_d;
	owner_t      context_d;
	logic        failed_d;

	logic   emit;
	token_t token_d;

	logic out_free;
	logic fire_s1;

	// The result register is free when it is empty or its word is being taken.
	// The input register moves on under the same condition, whether or not
	// its byte produces a token, so a byte per cycle flows through.
	assign out_free    = !valid_s2 || tokens.ready;
	assign fire_s1     = valid_s1 && out_free;
	assign bytes.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			byte_s1 <= bytes.data_byte;
		end
	end

	// One pass of the parser over the byte held in the input register.
	always_comb begin
		logic [63:0] shifted;
		logic [63:0] v;
		logic [3:0]  fb;
		logic        do_next_entry;
		logic        do_next_attr;
		logic        do_end_attrs;
		logic        done;
		logic [16:0] next_slot;
		logic [15:0] items_dec;
		logic [15:0] attrs_dec;
		logic [31:0] payload_dec;
		logic [15:0] idx;
		owner_t      own;

		section_d      = section_q;
		byte_pos_d     = byte_pos_q;
		acc_d          = acc_q;
		pool_slot_d    = pool_slot_q;
		pool_total_d   = pool_total_q;
		items_left_d   = items_left_q;
		item_number_d  = item_number_q;
		attrs_left_d   = attrs_left_q;
		attr_number_d  = attr_number_q;
		payload_left_d = payload_left_q;
		tag_d          = tag_q;
		context_d      = context_q;
		failed_d       = failed_q;
		emit           = 1'b0;
		do_next_entry  = 1'b0;
		do_next_attr   = 1'b0;
		do_end_attrs   = 1'b0;
		done           = 1'b0;
		next_slot      = 17'd0;

		shifted     = {acc_q[55:0], byte_s1};
		v           = shifted;
		fb          = field_bytes(section_q);
		items_dec   = items_left_q - 16'd1;
		attrs_dec   = attrs_left_q - 16'd1;
		payload_dec = payload_left_q - 32'd1;

		// Index and owner are taken from the state before this byte.
		idx = 16'd0;
		if (section_q >= KIND_TAG && section_q <= KIND_NAT_DESC) begin
			idx = pool_slot_q;
		end
		if (section_q == KIND_IFACE
				|| (section_q >= KIND_MEM_ACCESS && section_q <= KIND_MEM_DESC)) begin
			idx = item_number_q;
		end
		if (section_q == KIND_ATTR_COUNT
				&& (context_q == OWNER_FIELD || context_q == OWNER_METHOD)) begin
			idx = item_number_q;
		end
		if (section_q >= KIND_ATTR_NAME && section_q <= KIND_ATTR_BYTE) begin
			idx = attr_number_q;
		end
		own = OWNER_CLASS;
		if (section_q >= KIND_MEM_ACCESS && section_q <= KIND_ATTR_BYTE) begin
			own = context_q;
		end

		token_d.token_kind  = section_q;
		token_d.token_value = v;
		token_d.entry_index = idx;
		token_d.owner       = own;
		token_d.status      = STATUS_OK;
		token_d.class_done  = 1'b0;

		if (fire_s1 && !failed_q) begin
			if (({1'b0, byte_pos_q} + 4'd1) < fb) begin
				acc_d      = shifted;
				byte_pos_d = byte_pos_q + 3'd1;
			end else begin
				acc_d      = 64'd0;
				byte_pos_d = 3'd0;
				emit       = 1'b1;

				case (section_q)
					KIND_MAGIC: begin
						if (v[31:0] != MAGIC_WORD) begin
							failed_d            = 1'b1;
							token_d.token_kind  = KIND_ERROR;
							token_d.token_value = {32'd0, v[31:0]};
							token_d.entry_index = 16'd0;
							token_d.owner       = OWNER_CLASS;
							token_d.status      = STATUS_BAD_MAGIC;
						end else begin
							section_d = KIND_MINOR;
						end
					end
					KIND_MINOR:      section_d = KIND_MAJOR;
					KIND_MAJOR:      section_d = KIND_POOL_COUNT;
					KIND_POOL_COUNT: begin
						pool_total_d = v[15:0];
						pool_slot_d  = 16'd1;
						section_d    = (v[15:0] <= 16'd1) ? KIND_ACCESS : KIND_TAG;
					end
					KIND_TAG: begin
						tag_d = v[7:0];
						unique case (v[7:0]) inside
							TAG_UTF8:    section_d = KIND_UTF8_LEN;
							TAG_INTEGER: section_d = KIND_INTEGER;
							TAG_FLOAT:   section_d = KIND_FLOAT;
							TAG_LONG:    section_d = KIND_LONG;
							TAG_DOUBLE:  section_d = KIND_DOUBLE;
							TAG_CLASS:   section_d = KIND_CLASS_NAME;
							TAG_STRING:  section_d = KIND_STRING_IDX;
							TAG_FIELDREF, TAG_METHREF, TAG_IMETHREF:
								section_d = KIND_REF_CLASS;
							TAG_NAT:     section_d = KIND_NAT_NAME;
							default: begin
								failed_d            = 1'b1;
								token_d.token_kind  = KIND_ERROR;
								token_d.token_value = {56'd0, v[7:0]};
								token_d.owner       = OWNER_CLASS;
								token_d.status      = STATUS_BAD_TAG;
							end
						endcase
					end
					KIND_UTF8_LEN: begin
						payload_left_d = {16'd0, v[15:0]};
						if (v[15:0] == 16'd0) begin
							do_next_entry = 1'b1;
						end else begin
							section_d = KIND_UTF8_BYTE;
						end
					end
					KIND_UTF8_BYTE: begin
						payload_left_d = payload_dec;
						if (payload_dec == 32'd0) begin
							do_next_entry = 1'b1;
						end
					end
					KIND_REF_CLASS: section_d = KIND_REF_NAT;
					KIND_NAT_NAME:  section_d = KIND_NAT_DESC;
					KIND_INTEGER, KIND_FLOAT, KIND_LONG, KIND_DOUBLE,
					KIND_CLASS_NAME, KIND_STRING_IDX, KIND_REF_NAT, KIND_NAT_DESC:
						do_next_entry = 1'b1;
					KIND_ACCESS: section_d = KIND_THIS;
					KIND_THIS:   section_d = KIND_SUPER;
					KIND_SUPER:  section_d = KIND_IFACE_COUNT;
					KIND_IFACE_COUNT: begin
						items_left_d  = v[15:0];
						item_number_d = 16'd0;
						section_d = (v[15:0] == 16'd0) ? KIND_FIELD_COUNT : KIND_IFACE;
					end
					KIND_IFACE: begin
						item_number_d = item_number_q + 16'd1;
						items_left_d  = items_dec;
						if (items_dec == 16'd0) begin
							section_d = KIND_FIELD_COUNT;
						end
					end
					KIND_FIELD_COUNT, KIND_METHOD_COUNT: begin
						context_d = (section_q == KIND_FIELD_COUNT) ? OWNER_FIELD
							: OWNER_METHOD;
						items_left_d  = v[15:0];
						item_number_d = 16'd0;
						if (v[15:0] != 16'd0) begin
							section_d = KIND_MEM_ACCESS;
						end else if (section_q == KIND_FIELD_COUNT) begin
							section_d = KIND_METHOD_COUNT;
						end else begin
							context_d = OWNER_CLASS;
							section_d = KIND_ATTR_COUNT;
						end
					end
					KIND_MEM_ACCESS: section_d = KIND_MEM_NAME;
					KIND_MEM_NAME:   section_d = KIND_MEM_DESC;
					KIND_MEM_DESC:   section_d = KIND_ATTR_COUNT;
					KIND_ATTR_COUNT: begin
						attrs_left_d  = v[15:0];
						attr_number_d = 16'd0;
						if (v[15:0] == 16'd0) begin
							do_end_attrs = 1'b1;
						end else begin
							section_d = KIND_ATTR_NAME;
						end
					end
					KIND_ATTR_NAME: section_d = KIND_ATTR_LEN;
					KIND_ATTR_LEN: begin
						payload_left_d = v[31:0];
						if (v[31:0] == 32'd0) begin
							do_next_attr = 1'b1;
						end else begin
							section_d = KIND_ATTR_BYTE;
						end
					end
					default: begin
						// Attribute payload byte.
						payload_left_d = payload_dec;
						if (payload_dec == 32'd0) begin
							do_next_attr = 1'b1;
						end
					end
				endcase

				// Advance to the next pool slot; Long and Double take two.
				if (do_next_entry) begin
					next_slot = {1'b0, pool_slot_q}
						+ ((tag_q == TAG_LONG || tag_q == TAG_DOUBLE) ? 17'd2 : 17'd1);
					if (next_slot >= {1'b0, pool_total_q}) begin
						section_d = KIND_ACCESS;
					end else begin
						pool_slot_d = next_slot[15:0];
						section_d   = KIND_TAG;
					end
				end

				// One attribute finished.
				if (do_next_attr) begin
					attr_number_d = attr_number_q + 16'd1;
					attrs_left_d  = attrs_dec;
					if (attrs_dec == 16'd0) begin
						do_end_attrs = 1'b1;
					end else begin
						section_d = KIND_ATTR_NAME;
					end
				end

				// Attribute list finished: move to the next member, or the next
				// member list, or close the class when the list was its own.
				if (do_end_attrs) begin
					if (context_q != OWNER_FIELD && context_q != OWNER_METHOD) begin
						done = 1'b1;
					end else begin
						item_number_d = item_number_q + 16'd1;
						items_left_d  = items_dec;
						if (items_dec != 16'd0) begin
							section_d = KIND_MEM_ACCESS;
						end else if (context_q == OWNER_FIELD) begin
							section_d = KIND_METHOD_COUNT;
						end else begin
							context_d = OWNER_CLASS;
							section_d = KIND_ATTR_COUNT;
						end
					end
				end

				// Class complete: flag the token and wait for a new magic.
				if (done) begin
					token_d.class_done = 1'b1;
					section_d      = KIND_MAGIC;
					byte_pos_d     = 3'd0;
					acc_d          = 64'd0;
					pool_slot_d    = 16'd0;
					pool_total_d   = 16'd0;
					items_left_d   = 16'd0;
					item_number_d  = 16'd0;
					attrs_left_d   = 16'd0;
					attr_number_d  = 16'd0;
					payload_left_d = 32'd0;
					tag_d          = 8'd0;
					context_d      = OWNER_CLASS;
					failed_d       = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			section_q      <= KIND_MAGIC;
			byte_pos_q     <= 3'd0;
			acc_q          <= 64'd0;
			pool_slot_q    <= 16'd0;
			pool_total_q   <= 16'd0;
			items_left_q   <= 16'd0;
			item_number_q  <= 16'd0;
			attrs_left_q   <= 16'd0;
			attr_number_q  <= 16'd0;
			payload_left_q <= 32'd0;
			tag_q          <= 8'd0;
			context_q      <= OWNER_CLASS;
			failed_q       <= 1'b0;
		end else begin
			section_q      <= section_d;
			byte_pos_q     <= byte_pos_d;
			acc_q          <= acc_d;
			pool_slot_q    <= pool_slot_d;
			pool_total_q   <= pool_total_d;
			items_left_q   <= items_left_d;
			item_number_q  <= item_number_d;
			attrs_left_q   <= attrs_left_d;
			attr_number_q  <= attr_number_d;
			payload_left_q <= payload_left_d;
			tag_q          <= tag_d;
			context_q      <= context_d;
			failed_q       <= failed_d;
		end
	end

	// Result register: loads when free, holds while the sink stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit) begin
			token_s2 <= token_d;
		end
	end

	assign tokens.valid       = valid_s2;
	assign tokens.token_kind  = token_s2.token_kind;
	assign tokens.token_value = token_s2.token_value;
	assign tokens.entry_index = token_s2.entry_index;
	assign tokens.owner       = token_s2.owner;
	assign tokens.status      = token_s2.status;
	assign tokens.class_done  = token_s2.class_done;

endmodule

FILE: verif/tb_class_file_stream_tokenizer.sv
`timescale 1ns / 100ps

module tb_class_file_stream_tokenizer;

	import cfst_pkg::*;

	// Clock period is 2 ns, so the cycle limit below is in units of 2 ns.
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned STREAM_BYTES = 1150;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned MAX_IDLE     = 13;
	localparam int unsigned HOLD_AT      = 150;
	localparam int unsigned HOLD_CYCLES  = 500;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	cfst_byte_if  bytes_ch ();
	cfst_token_if tokens_ch ();

	class_file_stream_tokenizer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes_ch),
		.tokens (tokens_ch)
	);

	always #1 clk = ~clk;

	// One row of the directed table. Where fixed is set the token is typed
	// in by hand; every other row is checked against the predictor.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       fixed;
		token_t     tok;
	} stim_row_t;

	// The smallest complete class file: a pool count of one, so no entries,
	// and zero interfaces, fields, methods and class attributes. The bytes
	// also carry both extremes of the data field.
	localparam int DIR_ROWS = 24;
	localparam stim_row_t DIRECTED [DIR_ROWS] = '{
		'{8'hCA, 1'b0, '0},
		'{8'hFE, 1'b0, '0},
		'{8'hBA, 1'b0, '0},
		'{8'hBE, 1'b1, '{KIND_MAGIC, 64'hCAFE_BABE, 16'd0, OWNER_CLASS, STATUS_OK, 1'b0}},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b1, '{KIND_MINOR, 64'h0, 16'd0, OWNER_CLASS, STATUS_OK, 1'b0}},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b1, '{KIND_MAJOR, 64'hFFFF, 16'd0, OWNER_CLASS, STATUS_OK, 1'b0}},
		'{8'h00, 1'b0, '0},
		'{8'h01, 1'b1, '{KIND_POOL_COUNT, 64'h1, 16'd0, OWNER_CLASS, STATUS_OK, 1'b0}},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b1, '{KIND_ATTR_COUNT, 64'h0, 16'd0, OWNER_CLASS, STATUS_OK, 1'b1}}
	};

	localparam logic [7:0] GOOD_TAGS [11] = '{
		TAG_UTF8, TAG_INTEGER, TAG_FLOAT, TAG_LONG, TAG_DOUBLE, TAG_CLASS,
		TAG_STRING, TAG_FIELDREF, TAG_METHREF, TAG_IMETHREF, TAG_NAT
	};

	// The predictor's own copy of the parser state. The section code is the
	// token kind of the field being read.
	kind_t       sect;
	int unsigned byte_pos;
	logic [63:0] shift_acc;
	logic [15:0] pool_slot;
	logic [15:0] pool_total;
	logic [15:0] items_left;
	logic [15:0] item_no;
	logic [15:0] attrs_left;
	logic [15:0] attr_no;
	logic [31:0] payload_left;
	logic [7:0]  cur_tag;
	owner_t      owner_ctx;
	bit          halted;

	token_t      expected_tokens [$];
	logic [7:0]  class_bytes [$];
	int unsigned errors       = 0;
	int unsigned cycle_count  = 0;
	int unsigned tokens_taken = 0;
	bit          calm         = 1'b0;
	token_t      want;

	function automatic void parser_reset();
		sect         = KIND_MAGIC;
		byte_pos     = 0;
		shift_acc    = '0;
		pool_slot    = '0;
		pool_total   = '0;
		items_left   = '0;
		item_no      = '0;
		attrs_left   = '0;
		attr_no      = '0;
		payload_left = '0;
		cur_tag      = '0;
		owner_ctx    = OWNER_CLASS;
		halted       = 1'b0;
	endfunction

	// Number of bytes in the field that a section reads.
	function automatic int unsigned field_width(input kind_t s);
		case (s)
			KIND_MAGIC, KIND_INTEGER, KIND_FLOAT, KIND_ATTR_LEN: return 4;
			KIND_LONG, KIND_DOUBLE: return 8;
			KIND_TAG, KIND_UTF8_BYTE, KIND_ATTR_BYTE: return 1;
			default: return 2;
		endcase
	endfunction

	// Long and Double entries take two slots of the pool.
	function automatic void next_pool_entry();
		int unsigned step;
		int unsigned n;
		step = (cur_tag == TAG_LONG || cur_tag == TAG_DOUBLE) ? 2 : 1;
		n = int'(pool_slot) + step;
		if (n >= pool_total) begin
			sect = KIND_ACCESS;
		end else begin
			pool_slot = n[15:0];
			sect = KIND_TAG;
		end
	endfunction

	// An attribute list has ended. Returns one when that finishes the class.
	function automatic bit close_attr_list();
		if (owner_ctx != OWNER_FIELD && owner_ctx != OWNER_METHOD) return 1'b1;
		item_no++;
		items_left--;
		if (items_left != 0) begin
			sect = KIND_MEM_ACCESS;
		end else if (owner_ctx == OWNER_FIELD) begin
			sect = KIND_METHOD_COUNT;
		end else begin
			owner_ctx = OWNER_CLASS;
			sect = KIND_ATTR_COUNT;
		end
		return 1'b0;
	endfunction

	function automatic bit close_attribute();
		attr_no++;
		attrs_left--;
		if (attrs_left == 0) return close_attr_list();
		sect = KIND_ATTR_NAME;
		return 1'b0;
	endfunction

	// Takes one accepted byte and returns one when it finishes a field, with
	// the token that the block must emit for it.
	function automatic bit predict_token(input logic [7:0] b, output token_t tok);
		kind_t       s;
		logic [63:0] v;
		logic [15:0] idx;
		owner_t      own;
		bit          done;
		tok  = '0;
		idx  = '0;
		own  = OWNER_CLASS;
		done = 1'b0;
		if (halted) return 1'b0;
		s = sect;
		shift_acc = {shift_acc[55:0], b};
		if (byte_pos + 1 < field_width(s)) begin
			byte_pos++;
			return 1'b0;
		end
		v = shift_acc;
		shift_acc = '0;
		byte_pos = 0;

		if (s >= KIND_TAG && s <= KIND_NAT_DESC) idx = pool_slot;
		if (s == KIND_IFACE || (s >= KIND_MEM_ACCESS && s <= KIND_MEM_DESC)) idx = item_no;
		if (s == KIND_ATTR_COUNT && owner_ctx != OWNER_CLASS) idx = item_no;
		if (s >= KIND_ATTR_NAME && s <= KIND_ATTR_BYTE) idx = attr_no;
		if (s >= KIND_MEM_ACCESS && s <= KIND_ATTR_BYTE) own = owner_ctx;

		case (s)
			KIND_MAGIC: begin
				if (v[31:0] != MAGIC_WORD) begin
					halted = 1'b1;
					tok.token_kind  = KIND_ERROR;
					tok.token_value = {32'd0, v[31:0]};
					tok.status      = STATUS_BAD_MAGIC;
					return 1'b1;
				end
				sect = KIND_MINOR;
			end
			KIND_MINOR: sect = KIND_MAJOR;
			KIND_MAJOR: sect = KIND_POOL_COUNT;
			KIND_POOL_COUNT: begin
				pool_total = v[15:0];
				pool_slot = 16'd1;
				sect = (pool_total <= 1) ? KIND_ACCESS : KIND_TAG;
			end
			KIND_TAG: begin
				cur_tag = v[7:0];
				case (cur_tag)
					TAG_UTF8:    sect = KIND_UTF8_LEN;
					TAG_INTEGER: sect = KIND_INTEGER;
					TAG_FLOAT:   sect = KIND_FLOAT;
					TAG_LONG:    sect = KIND_LONG;
					TAG_DOUBLE:  sect = KIND_DOUBLE;
					TAG_CLASS:   sect = KIND_CLASS_NAME;
					TAG_STRING:  sect = KIND_STRING_IDX;
					TAG_FIELDREF, TAG_METHREF, TAG_IMETHREF: sect = KIND_REF_CLASS;
					TAG_NAT:     sect = KIND_NAT_NAME;
					default: begin
						halted = 1'b1;
						tok.token_kind  = KIND_ERROR;
						tok.token_value = {56'd0, cur_tag};
						tok.entry_index = idx;
						tok.status      = STATUS_BAD_TAG;
						return 1'b1;
					end
				endcase
			end
			KIND_UTF8_LEN: begin
				payload_left = {16'd0, v[15:0]};
				if (payload_left == 0) next_pool_entry();
				else sect = KIND_UTF8_BYTE;
			end
			KIND_UTF8_BYTE: begin
				payload_left--;
				if (payload_left == 0) next_pool_entry();
			end
			KIND_REF_CLASS: sect = KIND_REF_NAT;
			KIND_NAT_NAME:  sect = KIND_NAT_DESC;
			KIND_INTEGER, KIND_FLOAT, KIND_LONG, KIND_DOUBLE, KIND_CLASS_NAME,
			KIND_STRING_IDX, KIND_REF_NAT, KIND_NAT_DESC: next_pool_entry();
			KIND_ACCESS: sect = KIND_THIS;
			KIND_THIS:   sect = KIND_SUPER;
			KIND_SUPER:  sect = KIND_IFACE_COUNT;
			KIND_IFACE_COUNT: begin
				items_left = v[15:0];
				item_no = '0;
				sect = (items_left == 0) ? KIND_FIELD_COUNT : KIND_IFACE;
			end
			KIND_IFACE: begin
				item_no++;
				items_left--;
				if (items_left == 0) sect = KIND_FIELD_COUNT;
			end
			KIND_FIELD_COUNT, KIND_METHOD_COUNT: begin
				owner_ctx = (s == KIND_FIELD_COUNT) ? OWNER_FIELD : OWNER_METHOD;
				items_left = v[15:0];
				item_no = '0;
				if (items_left != 0) begin
					sect = KIND_MEM_ACCESS;
				end else if (s == KIND_FIELD_COUNT) begin
					sect = KIND_METHOD_COUNT;
				end else begin
					owner_ctx = OWNER_CLASS;
					sect = KIND_ATTR_COUNT;
				end
			end
			KIND_MEM_ACCESS: sect = KIND_MEM_NAME;
			KIND_MEM_NAME:   sect = KIND_MEM_DESC;
			KIND_MEM_DESC:   sect = KIND_ATTR_COUNT;
			KIND_ATTR_COUNT: begin
				attrs_left = v[15:0];
				attr_no = '0;
				if (attrs_left == 0) done = close_attr_list();
				else sect = KIND_ATTR_NAME;
			end
			KIND_ATTR_NAME: sect = KIND_ATTR_LEN;
			KIND_ATTR_LEN: begin
				payload_left = v[31:0];
				if (payload_left == 0) done = close_attribute();
				else sect = KIND_ATTR_BYTE;
			end
			default: begin
				// Attribute payload byte.
				payload_left--;
				if (payload_left == 0) done = close_attribute();
			end
		endcase

		tok.token_kind  = s;
		tok.token_value = v;
		tok.entry_index = idx;
		tok.owner       = own;
		tok.status      = STATUS_OK;
		tok.class_done  = done;
		if (done) parser_reset();
		return 1'b1;
	endfunction

	// Appends the low n bytes of v to the stream, most significant first.
	function automatic void put_bytes(input logic [63:0] v, input int n);
		for (int k = n - 1; k >= 0; k--) class_bytes = {class_bytes, v[8 * k +: 8]};
	endfunction

	// An attribute list: count, then name, length and payload for each. A
	// few payloads are long enough to run well past the short ones.
	function automatic void build_attrs();
		int unsigned n;
		int unsigned len;
		n = $urandom_range(0, 2);
		put_bytes(n, 2);
		repeat (n) begin
			put_bytes($urandom, 2);
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
			put_bytes(len, 4);
			repeat (len) put_bytes($urandom, 1);
		end
	endfunction

	// A well-formed class file with random content. Pool counts of zero and
	// one, every valid tag, and a Long or Double in the last slot all come up.
	function automatic void build_class();
		int unsigned n_pool;
		int unsigned slot;
		int unsigned n;
		logic [7:0]  t;
		put_bytes(MAGIC_WORD, 4);
		put_bytes($urandom, 4);
		n_pool = $urandom_range(0, 9);
		put_bytes(n_pool, 2);
		slot = 1;
		while (slot < n_pool) begin
			t = GOOD_TAGS[$urandom_range(0, 10)];
			put_bytes(t, 1);
			case (t)
				TAG_UTF8: begin
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
						$urandom_range(0, 5);
					put_bytes(n, 2);
					repeat (n) put_bytes($urandom, 1);
				end
				TAG_LONG, TAG_DOUBLE: put_bytes({$urandom, $urandom}, 8);
				TAG_CLASS, TAG_STRING: put_bytes($urandom, 2);
				// Integer, Float, the three refs and NameAndType are four bytes.
				default: put_bytes($urandom, 4);
			endcase
			slot += (t == TAG_LONG || t == TAG_DOUBLE) ? 2 : 1;
		end
		put_bytes({$urandom, $urandom}, 6);
		n = $urandom_range(0, 3);
		put_bytes(n, 2);
		repeat (n) put_bytes($urandom, 2);
		// Fields first, then methods, each with its own attributes.
		for (int m = 0; m < 2; m++) begin
			n = $urandom_range(0, 3);
			put_bytes(n, 2);
			repeat (n) begin
				put_bytes({$urandom, $urandom}, 6);
				build_attrs();
			end
		end
		build_attrs();
	endfunction

	function automatic void check_field(input string name, input logic [63:0] exp_v,
		input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name,
				exp_v, act_v);
		end
	endfunction

	// Offers one byte after a random gap, waits for the handshake and then
	// works out the token, if any, that the word should give.
	task automatic send_byte(input logic [7:0] b, input bit fixed, input token_t fixed_tok);
		int unsigned gap;
		token_t      tok;
		bit          hit;
		if ($urandom_range(0, 99) == 0) calm = !calm;
		gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap != 0) begin
			bytes_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		bytes_ch.valid <= 1'b1;
		bytes_ch.data_byte <= b;
		do @(posedge clk); while (!(bytes_ch.valid && bytes_ch.ready));
		hit = predict_token(b, tok);
		if (fixed) expected_tokens = {expected_tokens, fixed_tok};
		else if (hit) expected_tokens = {expected_tokens, tok};
		@(negedge clk);
	endtask

	// Stimulus and the end of the run.
	initial begin
		logic [31:0] word;
		logic [7:0]  t;
		bytes_ch.valid = 1'b0;
		bytes_ch.data_byte = 8'h00;
		parser_reset();

		// Random classes until the stream is long enough. An error stops the
		// block for good, since reset is applied only once, so the stream
		// ends with one malformed file: a bad magic or an unknown tag. The
		// bytes after it must be swallowed without a token.
		while (class_bytes.size() < STREAM_BYTES) build_class();
		if ($urandom_range(0, 1) == 0) begin
			word = $urandom;
			if (word == MAGIC_WORD) word[0] = ~word[0];
			put_bytes(word, 4);
		end else begin
			put_bytes(MAGIC_WORD, 4);
			put_bytes($urandom, 4);
			put_bytes($urandom_range(3, 9), 2);
			put_bytes(TAG_INTEGER, 1);
			put_bytes($urandom, 4);
			// Map onto the tags that are not defined: zero, two and 13 up.
			t = $urandom_range(0, 244);
			if (t == 8'd1) t = 8'd2;
			else if (t > 8'd1) t = t + 8'd11;
			put_bytes(t, 1);
		end
		repeat (4) put_bytes($urandom, 1);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			send_byte(DIRECTED[i].data_byte, DIRECTED[i].fixed, DIRECTED[i].tok);
		foreach (class_bytes[i]) send_byte(class_bytes[i], 1'b0, '0);
		bytes_ch.valid <= 1'b0;

		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_tokens.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Token receiver. It stalls for a random number of cycles before each
	// word, except in calm stretches. Once in the run it holds off for a long
	// stretch so that the output and input registers fill and the block has
	// to push back on the byte stream.
	initial begin
		int unsigned stall;
		tokens_ch.ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		tokens_ch.ready <= 1'b1;
		forever begin
			stall = calm ? 0 : $urandom_range(0, MAX_IDLE);
			if (tokens_taken == HOLD_AT) stall = HOLD_CYCLES;
			if (stall != 0) begin
				tokens_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			tokens_ch.ready <= 1'b1;
			do @(posedge clk); while (!(tokens_ch.valid && tokens_ch.ready));
			tokens_taken++;
			@(negedge clk);
		end
	end

	// Every accepted token is matched against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && tokens_ch.valid && tokens_ch.ready) begin
			if (expected_tokens.size() == 0) begin
				errors++;
				$display("%0t: token with none expected, expected nothing, actual kind %0d value 0x%0h",
					$time, tokens_ch.token_kind, tokens_ch.token_value);
			end else begin
				want = expected_tokens.pop_front();
				check_field("token_kind", want.token_kind, tokens_ch.token_kind);
				check_field("token_value", want.token_value, tokens_ch.token_value);
				check_field("entry_index", want.entry_index, tokens_ch.entry_index);
				check_field("owner", want.owner, tokens_ch.owner);
				check_field("status", want.status, tokens_ch.status);
				check_field("class_done", want.class_done, tokens_ch.class_done);
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

endmodule
